/* rtl/sfs_pkg.sv */
// sfs_pkg: widths, register indexes and divider request/response types
// for the sprite frame sequencer. No dependencies.
package sfs_pkg;

  localparam int unsigned TimeW    = 25;
  localparam int unsigned DurW     = 24;
  localparam int unsigned DtW      = 16;
  localparam int unsigned FcW      = 13;
  localparam int unsigned ColsW    = 9;
  localparam int unsigned PixW     = 13;
  localparam int unsigned FrameW   = 12;
  localparam int unsigned ColW     = 8;
  localparam int unsigned RectXW   = 20;
  localparam int unsigned RectYW   = 24;
  localparam int unsigned ProdW    = 37;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned StepW    = 5;

  // divider step counts
  localparam logic [StepW-1:0] ModSteps   = 5'd25;
  localparam logic [StepW-1:0] FrameSteps = 5'd12;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_ACTIVE        = 3'd0,
    CFG_FRAME_COUNT   = 3'd1,
    CFG_SHEET_COLUMNS = 3'd2,
    CFG_FRAME_WIDTH   = 3'd3,
    CFG_FRAME_HEIGHT  = 3'd4,
    CFG_DURATION      = 3'd5,
    CFG_LOOP_MODE     = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    REQ_TICK    = 1'b0,
    REQ_RESTART = 1'b1
  } req_type_e;

  // request to the shared divider: rem is the starting partial remainder,
  // dividend is left-justified and consumed msb first
  typedef struct packed {
    logic             start;
    logic [StepW-1:0] steps;
    logic [DurW-1:0]  rem;
    logic [TimeW-1:0] dividend;
    logic [DurW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [TimeW-1:0] quotient;
    logic [DurW-1:0]  remainder;
  } div_rsp_t;

endpackage

/* rtl/sfs_if.sv */
// sfs_if: valid/ready channel interfaces for the sprite frame sequencer
// (input requests, result rectangles, register writes). Depends on sfs_pkg.
interface sfs_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [sfs_pkg::DtW-1:0]  elapsed_ticks;

  modport source (output valid, req_type, elapsed_ticks, input ready);
  modport sink   (input valid, req_type, elapsed_ticks, output ready);
endinterface

interface sfs_out_if;
  logic                       valid;
  logic                       ready;
  logic [sfs_pkg::RectXW-1:0] rect_x;
  logic [sfs_pkg::RectYW-1:0] rect_y;
  logic [sfs_pkg::PixW-1:0]   rect_w;
  logic [sfs_pkg::PixW-1:0]   rect_h;
  logic [sfs_pkg::FrameW-1:0] frame_index;
  logic                       finished;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, frame_index, finished,
                  input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, frame_index, finished,
                  output ready);
endinterface

interface sfs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfs_pkg::CfgAddrW-1:0] addr;
  logic [sfs_pkg::CfgDataW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

/* rtl/sfs_divider.sv */
// sfs_divider: radix-2 restoring divider, one quotient bit per cycle.
// Depends on sfs_pkg.
module sfs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfs_pkg::div_req_t req_i,
  output sfs_pkg::div_rsp_t rsp_o
);
  import sfs_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [StepW-1:0] cnt_q;
  logic [DurW-1:0]  rem_q;
  logic [TimeW-1:0] dvd_q;
  logic [TimeW-1:0] quo_q;
  logic [DurW-1:0]  dsr_q;

  logic [DurW:0] rem_sh;
  logic [DurW:0] rem_sub;
  logic          fits;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_q, dvd_q[TimeW-1]};
    fits    = (rem_sh >= {1'b0, dsr_q});
    rem_sub = rem_sh - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.steps;
        rem_q  <= req_i.rem;
        dvd_q  <= req_i.dividend;
        dsr_q  <= req_i.divisor;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q  <= fits ? rem_sub[DurW-1:0] : rem_sh[DurW-1:0];
        quo_q  <= {quo_q[TimeW-2:0], fits};
        dvd_q  <= {dvd_q[TimeW-2:0], 1'b0};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

/* rtl/sprite_frame_sequencer.sv */
// sprite_frame_sequencer: top level of the sprite-sheet animation sequencer.
// Depends on sfs_pkg, sfs_if (channel interfaces) and sfs_divider.
//
// A tick request adds its elapsed ticks to the time accumulator (unless a
// one-shot pass has finished) and returns the source rectangle of frame
// floor(time * frame_count / duration) in the sprite sheet; loop mode keeps the
// time modulo the duration, one-shot mode saturates it and holds the last frame
// with a sticky finished flag. A restart request clears time and the flag and
// returns nothing; ticks while not active return nothing. Requests are taken
// one at a time. The single shared radix-2 divider does 25 steps for the
// time modulo (loop mode only), 12 for scaling time to a frame number (skipped
// when a one-shot pass ends or has ended) and 12 for splitting the frame into
// sheet column and row; one shared 24x13 multiplier handles the three products.
// A finished result waits in the output register, so the next request can
// start while it is still pending. Register writes are always accepted.
module sprite_frame_sequencer (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfs_in_if.sink    in_req_i,
  sfs_out_if.source out_rsp_o,
  sfs_cfg_if.sink   cfg_i
);
  import sfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_MOD,
    S_MUL_T,
    S_FDIV_GO,
    S_FDIV,
    S_CR_GO,
    S_CR,
    S_MUL_X,
    S_MUL_Y,
    S_DONE
  } state_e;

  // configuration registers
  logic             active_q;
  logic [FcW-1:0]   frame_count_q;
  logic [ColsW-1:0] sheet_columns_q;
  logic [PixW-1:0]  frame_width_q;
  logic [PixW-1:0]  frame_height_q;
  logic [DurW-1:0]  duration_q;
  logic             loop_mode_q;

  // sequencer and working registers
  state_e           state_q;
  logic [TimeW-1:0] time_q;
  logic             ended_q;
  logic [DtW-1:0]   dt_q;
  logic [ProdW-1:0] prod_q;
  logic [FrameW-1:0] frame_q;
  logic [ColW-1:0]  col_q;
  logic [FrameW-1:0] row_q;
  logic [RectXW-1:0] x_q;
  div_req_t         div_req_q;
  div_rsp_t         div_rsp;

  // output register
  logic              out_valid_q;
  logic [RectXW-1:0] rect_x_q;
  logic [RectYW-1:0] rect_y_q;
  logic [PixW-1:0]   rect_w_q;
  logic [PixW-1:0]   rect_h_q;
  logic [FrameW-1:0] frame_idx_q;
  logic              finished_q;

  // clamped register views
  logic [FcW-1:0]   fc;
  logic [ColsW-1:0] cols;
  logic [PixW-1:0]  fw;
  logic [PixW-1:0]  fh;
  logic [DurW-1:0]  dur;

  logic [TimeW-1:0] time_new;
  logic [DurW-1:0]  mul_a;
  logic [FcW-1:0]   mul_b;
  logic [ProdW-1:0] mul_p;

  logic in_take;
  logic out_take;

  always_comb begin
    fc   = (frame_count_q == '0) ? 13'd1 :
           (frame_count_q > 13'd4096) ? 13'd4096 : frame_count_q;
    cols = (sheet_columns_q == '0) ? 9'd1 :
           (sheet_columns_q > 9'd256) ? 9'd256 : sheet_columns_q;
    fw   = (frame_width_q == '0) ? 13'd1 :
           (frame_width_q > 13'd4096) ? 13'd4096 : frame_width_q;
    fh   = (frame_height_q == '0) ? 13'd1 :
           (frame_height_q > 13'd4096) ? 13'd4096 : frame_height_q;
    dur  = (duration_q == '0) ? 24'd1 : duration_q;
  end

  // accumulator update, wraps at 25 bits; frozen once a one-shot pass ended
  assign time_new = ended_q ? time_q : (time_q + {{(TimeW-DtW){1'b0}}, dt_q});

  // shared multiplier: time*frames, column*width, row*height
  always_comb begin
    unique case (state_q)
      S_MUL_X: begin
        mul_a = {{(DurW-ColW){1'b0}}, col_q};
        mul_b = fw;
      end
      S_MUL_Y: begin
        mul_a = {{(DurW-FrameW){1'b0}}, row_q};
        mul_b = fh;
      end
      default: begin
        mul_a = time_q[DurW-1:0];
        mul_b = fc;
      end
    endcase
    mul_p = {{(ProdW-DurW){1'b0}}, mul_a} * {{(ProdW-FcW){1'b0}}, mul_b};
  end

  sfs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign in_req_i.ready = (state_q == S_IDLE);
  assign in_take        = in_req_i.valid && in_req_i.ready;
  assign out_take       = out_valid_q && out_rsp_o.ready;

  // register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q        <= 1'b0;
      frame_count_q   <= 13'd1;
      sheet_columns_q <= 9'd1;
      frame_width_q   <= 13'd1;
      frame_height_q  <= 13'd1;
      duration_q      <= 24'd1;
      loop_mode_q     <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.addr))
        CFG_ACTIVE:        active_q        <= cfg_i.data[0];
        CFG_FRAME_COUNT:   frame_count_q   <= cfg_i.data[FcW-1:0];
        CFG_SHEET_COLUMNS: sheet_columns_q <= cfg_i.data[ColsW-1:0];
        CFG_FRAME_WIDTH:   frame_width_q   <= cfg_i.data[PixW-1:0];
        CFG_FRAME_HEIGHT:  frame_height_q  <= cfg_i.data[PixW-1:0];
        CFG_DURATION:      duration_q      <= cfg_i.data[DurW-1:0];
        CFG_LOOP_MODE:     loop_mode_q     <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // sequencer, state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      ended_q     <= 1'b0;
      dt_q        <= '0;
      prod_q      <= '0;
      frame_q     <= '0;
      col_q       <= '0;
      row_q       <= '0;
      x_q         <= '0;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
      rect_x_q    <= '0;
      rect_y_q    <= '0;
      rect_w_q    <= '0;
      rect_h_q    <= '0;
      frame_idx_q <= '0;
      finished_q  <= 1'b0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_take) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            if (req_type_e'(in_req_i.req_type) == REQ_RESTART) begin
              time_q  <= '0;
              ended_q <= 1'b0;
            end else if (active_q) begin
              dt_q    <= in_req_i.elapsed_ticks;
              state_q <= S_ADD;
            end
          end
        end

        S_ADD: begin
          if (loop_mode_q) begin
            // time modulo duration
            time_q             <= time_new;
            div_req_q.start    <= 1'b1;
            div_req_q.steps    <= ModSteps;
            div_req_q.rem      <= '0;
            div_req_q.dividend <= time_new;
            div_req_q.divisor  <= dur;
            state_q            <= S_MOD;
          end else if (time_new >= {1'b0, dur}) begin
            // one-shot end: hold last frame
            time_q  <= {1'b0, dur};
            ended_q <= 1'b1;
            frame_q <= 12'(fc - 13'd1);
            state_q <= S_CR_GO;
          end else begin
            time_q  <= time_new;
            state_q <= S_MUL_T;
          end
        end

        S_MOD: begin
          if (div_rsp.done) begin
            time_q  <= {1'b0, div_rsp.remainder};
            state_q <= S_MUL_T;
          end
        end

        S_MUL_T: begin
          prod_q  <= mul_p;
          state_q <= S_FDIV_GO;
        end

        S_FDIV_GO: begin
          // upper part of the product is already below the duration,
          // so only 12 quotient bits remain
          div_req_q.start    <= 1'b1;
          div_req_q.steps    <= FrameSteps;
          div_req_q.rem      <= prod_q[ProdW-2:FrameW];
          div_req_q.dividend <= {prod_q[FrameW-1:0], {(TimeW-FrameW){1'b0}}};
          div_req_q.divisor  <= dur;
          state_q            <= S_FDIV;
        end

        S_FDIV: begin
          if (div_rsp.done) begin
            frame_q <= div_rsp.quotient[FrameW-1:0];
            state_q <= S_CR_GO;
          end
        end

        S_CR_GO: begin
          div_req_q.start    <= 1'b1;
          div_req_q.steps    <= FrameSteps;
          div_req_q.rem      <= '0;
          div_req_q.dividend <= {frame_q, {(TimeW-FrameW){1'b0}}};
          div_req_q.divisor  <= {{(DurW-ColsW){1'b0}}, cols};
          state_q            <= S_CR;
        end

        S_CR: begin
          if (div_rsp.done) begin
            col_q   <= div_rsp.remainder[ColW-1:0];
            row_q   <= div_rsp.quotient[FrameW-1:0];
            state_q <= S_MUL_X;
          end
        end

        S_MUL_X: begin
          prod_q  <= mul_p;
          state_q <= S_MUL_Y;
        end

        S_MUL_Y: begin
          x_q     <= prod_q[RectXW-1:0];
          prod_q  <= mul_p;
          state_q <= S_DONE;
        end

        S_DONE: begin
          // wait for the output register to be free
          if (!out_valid_q || out_rsp_o.ready) begin
            out_valid_q <= 1'b1;
            rect_x_q    <= x_q;
            rect_y_q    <= prod_q[RectYW-1:0];
            rect_w_q    <= fw;
            rect_h_q    <= fh;
            frame_idx_q <= frame_q;
            finished_q  <= ended_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_rsp_o.valid       = out_valid_q;
  assign out_rsp_o.rect_x      = rect_x_q;
  assign out_rsp_o.rect_y      = rect_y_q;
  assign out_rsp_o.rect_w      = rect_w_q;
  assign out_rsp_o.rect_h      = rect_h_q;
  assign out_rsp_o.frame_index = frame_idx_q;
  assign out_rsp_o.finished    = finished_q;

endmodule

/* tb/sv/sprite_frame_sequencer_checker.sv */
`timescale 1ns / 1ps
// sprite_frame_sequencer_checker: watches the request, result and register channels,
// predicts each result rectangle and compares it field by field.
// Depends on sfs_pkg and the channel interfaces in sfs_if.
module sprite_frame_sequencer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfs_in_if           req_mon,
  sfs_out_if          rsp_mon,
  sfs_cfg_if          cfg_mon,
  output int unsigned mismatches_o,
  output int unsigned rects_pending_o
);
  import sfs_pkg::*;

  localparam int unsigned MaxFrames  = 4096;
  localparam int unsigned MaxColumns = 256;
  localparam int unsigned MaxPixels  = 4096;

  typedef struct packed {
    logic [RectXW-1:0] x;
    logic [RectYW-1:0] y;
    logic [PixW-1:0]   w;
    logic [PixW-1:0]   h;
    logic [FrameW-1:0] frame;
    logic              finished;
  } sheet_rect_t;

  // register copies, at register width
  logic             active_q;
  logic [FcW-1:0]   frames_q;
  logic [ColsW-1:0] columns_q;
  logic [PixW-1:0]  width_q;
  logic [PixW-1:0]  height_q;
  logic [DurW-1:0]  duration_q;
  logic             loop_q;

  // playback state
  logic [TimeW-1:0] play_time;
  logic             ended;

  sheet_rect_t pending_rects[$];
  int unsigned n_mismatch = 0;

  assign mismatches_o = n_mismatch;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // moves playback on by one request, returns 1 when a rectangle comes out
  function automatic bit advance_playback(input req_type_e kind, input logic [DtW-1:0] dt,
                                          output sheet_rect_t rect);
    int unsigned fc, cols, fw, fh, dur, frame;
    rect = '0;
    if (kind == REQ_RESTART) begin
      play_time = '0;
      ended     = 1'b0;
      return 1'b0;
    end
    if (!active_q) return 1'b0;
    fc   = clamp_to(frames_q, MaxFrames);
    cols = clamp_to(columns_q, MaxColumns);
    fw   = clamp_to(width_q, MaxPixels);
    fh   = clamp_to(height_q, MaxPixels);
    dur  = (duration_q == '0) ? 1 : duration_q;
    if (!ended) play_time = play_time + dt;
    if (loop_q) begin
      play_time = TimeW'(play_time % dur);
      frame     = 32'((64'(play_time) * fc) / dur);
    end else if (play_time >= dur) begin
      // one-shot end: hold the last frame, time saturates
      play_time = TimeW'(dur);
      frame     = fc - 1;
      ended     = 1'b1;
    end else begin
      frame = 32'((64'(play_time) * fc) / dur);
    end
    rect.x        = RectXW'((frame % cols) * fw);
    rect.y        = RectYW'((frame / cols) * fh);
    rect.w        = PixW'(fw);
    rect.h        = PixW'(fh);
    rect.frame    = FrameW'(frame);
    rect.finished = ended;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t checker: %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sheet_rect_t rect, want;
    if (!rst_ni) begin
      active_q   = 1'b0;
      frames_q   = FcW'(1);
      columns_q  = ColsW'(1);
      width_q    = PixW'(1);
      height_q   = PixW'(1);
      duration_q = DurW'(1);
      loop_q     = 1'b1;
      play_time  = '0;
      ended      = 1'b0;
      pending_rects.delete();
      rects_pending_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pending_rects.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = pending_rects.pop_front();
          check_field("rect_x", rsp_mon.rect_x, want.x);
          check_field("rect_y", rsp_mon.rect_y, want.y);
          check_field("rect_w", rsp_mon.rect_w, want.w);
          check_field("rect_h", rsp_mon.rect_h, want.h);
          check_field("frame_index", rsp_mon.frame_index, want.frame);
          check_field("finished", rsp_mon.finished, want.finished);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.addr))
          CFG_ACTIVE:        active_q   = cfg_mon.data[0];
          CFG_FRAME_COUNT:   frames_q   = cfg_mon.data[FcW-1:0];
          CFG_SHEET_COLUMNS: columns_q  = cfg_mon.data[ColsW-1:0];
          CFG_FRAME_WIDTH:   width_q    = cfg_mon.data[PixW-1:0];
          CFG_FRAME_HEIGHT:  height_q   = cfg_mon.data[PixW-1:0];
          CFG_DURATION:      duration_q = cfg_mon.data[DurW-1:0];
          CFG_LOOP_MODE:     loop_q     = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        if (advance_playback(req_type_e'(req_mon.req_type), req_mon.elapsed_ticks, rect)) begin
          pending_rects.push_back(rect);
        end
      end
      rects_pending_o <= pending_rects.size();
    end
  end

endmodule

/* tb/sv/sprite_frame_sequencer_tb.sv */
`timescale 1ns / 1ps
// sprite_frame_sequencer_tb: drives requests and register writes into the sequencer,
// stalls the result side and gives the verdict. Depends on sfs_pkg, sfs_if,
// the sequencer RTL and sprite_frame_sequencer_checker.
module sprite_frame_sequencer_tb;
  import sfs_pkg::*;

  // long enough to cover any tick still in flight
  localparam int unsigned SettleCycles = 80;
  // requests sent while active in the random part
  localparam int unsigned RandomItems  = 1100;
  localparam int unsigned TimeoutNs    = 12_000_000;

  logic clk_i;
  logic rst_ni;

  int unsigned mismatches;
  int unsigned rects_pending;

  // calm: the last part of the run, with no idling on either side
  bit              calm      = 1'b0;
  int unsigned     gap_pct   = 0;
  int unsigned     stall_pct = 30;
  // shadow of what was last written, used only to shape the stimulus
  logic [DurW-1:0] cur_dur    = DurW'(1);
  logic            cur_active = 1'b0;

  sfs_in_if  req_if ();
  sfs_out_if rsp_if ();
  sfs_cfg_if cfg_if ();

  sprite_frame_sequencer i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (req_if),
    .out_rsp_o (rsp_if),
    .cfg_i     (cfg_if)
  );

  sprite_frame_sequencer_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_mon         (req_if),
    .rsp_mon         (rsp_if),
    .cfg_mon         (cfg_if),
    .mismatches_o    (mismatches),
    .rects_pending_o (rects_pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #TimeoutNs;
    $display("tb: failure");
    $finish;
  end

  // result side: random bursts of back-pressure, none once calm
  initial begin : result_stalls
    int unsigned n;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        rsp_if.ready <= 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // one request; valid stays high on return so back-to-back requests need no gap
  task automatic send_req(input req_type_e kind, input logic [DtW-1:0] dt);
    req_if.valid         <= 1'b1;
    req_if.req_type      <= kind;
    req_if.elapsed_ticks <= dt;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop sending and wait until every predicted rectangle has come back
  task automatic quiesce();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (rects_pending != 0);
  endtask

  // quiesce, then let a request that gives no result finish too
  task automatic settle();
    quiesce();
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_DURATION) cur_dur = value[DurW-1:0];
    if (idx == CFG_ACTIVE) cur_active = value[0];
  endtask

  task automatic write_all(input logic act, input int unsigned fc, input int unsigned cols,
                           input int unsigned fw, input int unsigned fh,
                           input int unsigned dur, input logic loop_on);
    write_reg(CFG_ACTIVE, CfgDataW'(act));
    write_reg(CFG_FRAME_COUNT, CfgDataW'(fc));
    write_reg(CFG_SHEET_COLUMNS, CfgDataW'(cols));
    write_reg(CFG_FRAME_WIDTH, CfgDataW'(fw));
    write_reg(CFG_FRAME_HEIGHT, CfgDataW'(fh));
    write_reg(CFG_DURATION, CfgDataW'(dur));
    write_reg(CFG_LOOP_MODE, CfgDataW'(loop_on));
  endtask

  // mostly short animations so that frames wrap and one-shot passes end,
  // with the extremes and out-of-range values mixed in
  task automatic random_settings(input logic act);
    int unsigned fc, cols, dur;
    case ($urandom_range(0, 9))
      0:       fc = $urandom_range(0, 8191);
      1:       fc = 4096;
      default: fc = $urandom_range(1, 64);
    endcase
    case ($urandom_range(0, 9))
      0:       cols = $urandom_range(0, 511);
      1:       cols = 256;
      default: cols = $urandom_range(1, 16);
    endcase
    case ($urandom_range(0, 9))
      0:       dur = $urandom_range(0, 24'hFFFFFF);
      1:       dur = 24'hFFFFFF;
      2:       dur = 0;
      default: dur = $urandom_range(1, 4000);
    endcase
    write_all(act, fc, cols, $urandom_range(0, 8191), $urandom_range(0, 8191), dur,
              logic'($urandom_range(0, 1)));
  endtask

  // elapsed ticks scaled to the duration, so a pass spans several ticks
  function automatic logic [DtW-1:0] pick_ticks();
    int unsigned span;
    span = (cur_dur > 4 * 65535) ? 65535 : cur_dur / 4 + 1;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return DtW'($urandom);
      default: return DtW'($urandom_range(0, span));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned sent, n, phase;
    rst_ni               = 1'b0;
    req_if.valid         <= 1'b0;
    req_if.req_type      <= REQ_TICK;
    req_if.elapsed_ticks <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.addr          <= CFG_ACTIVE;
    cfg_if.data          <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset: not active, so a tick gives nothing; restart always gives nothing
    send_req(REQ_TICK, '1);
    send_req(REQ_RESTART, '0);

    // largest sheet, longest duration, loop
    settle();
    write_all(1'b1, 4096, 256, 4096, 4096, 24'hFFFFFF, 1'b1);
    send_req(REQ_TICK, '0);
    send_req(REQ_TICK, '1);
    send_req(REQ_RESTART, '1);
    send_req(REQ_TICK, 16'h8000);

    // time just short of the duration reaches the last frame, bottom-right of the sheet,
    // then one more tick wraps back to frame zero
    settle();
    write_reg(CFG_DURATION, 24'd65536);
    send_req(REQ_RESTART, '0);
    send_req(REQ_TICK, '1);
    send_req(REQ_TICK, 16'd1);

    // smallest everything, one-shot: finish, tick after finish holds, restart clears
    settle();
    write_all(1'b1, 1, 1, 1, 1, 1, 1'b0);
    send_req(REQ_TICK, '0);
    send_req(REQ_TICK, 16'd1);
    send_req(REQ_TICK, 16'd5);
    send_req(REQ_RESTART, '0);
    send_req(REQ_TICK, '0);

    // zero registers are taken as one
    settle();
    write_all(1'b1, 0, 0, 0, 0, 0, 1'b1);
    send_req(REQ_TICK, 16'd3);

    // values above the maximum are clamped; one-shot runs to its end
    settle();
    write_all(1'b1, 8191, 511, 8191, 8191, 100, 1'b0);
    send_req(REQ_TICK, 16'd40);
    send_req(REQ_TICK, 16'd59);
    send_req(REQ_TICK, 16'd7);

    // duration shrunk below the elapsed time: one-shot saturates and finishes
    settle();
    write_all(1'b1, 16, 4, 32, 32, 1000, 1'b0);
    send_req(REQ_RESTART, '0);
    send_req(REQ_TICK, 16'd900);
    settle();
    write_reg(CFG_DURATION, 24'd500);
    send_req(REQ_TICK, '0);

    // same in loop mode: the time wraps modulo the new duration
    settle();
    write_reg(CFG_LOOP_MODE, CfgDataW'(1));
    write_reg(CFG_DURATION, 24'd1000);
    send_req(REQ_RESTART, '0);
    send_req(REQ_TICK, 16'd900);
    settle();
    write_reg(CFG_DURATION, 24'd400);
    send_req(REQ_TICK, '0);

    // an inactive tick leaves the time alone
    settle();
    write_reg(CFG_ACTIVE, CfgDataW'(0));
    send_req(REQ_TICK, 16'd50);
    settle();
    write_reg(CFG_ACTIVE, CfgDataW'(1));
    send_req(REQ_TICK, '0);

    // random part: a new setting per phase, mostly ticks with the odd restart
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      settle();
      n = $urandom_range(40, 140);
      if (sent + n >= RandomItems) calm = 1'b1;
      case ($urandom_range(0, 2))
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 15; stall_pct = 20; end
        default: begin gap_pct = 40; stall_pct = 50; end
      endcase
      if (calm) begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      random_settings(logic'(phase % 7 != 5 || calm));
      for (int i = 0; i < n; i++) begin
        if (phase == 1 && i == n / 2) begin
          // hold off until every rectangle in flight has been taken
          quiesce();
        end else if ($urandom_range(0, 99) < gap_pct) begin
          req_if.valid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(posedge clk_i);
        end
        send_req(($urandom_range(0, 11) == 0) ? REQ_RESTART : REQ_TICK, pick_ticks());
        if (cur_active) sent++;
      end
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
